// ===== rtl/blt_pkg.sv =====
`timescale 1ns / 1ps
package blt_pkg;

  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 128;
  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  // Wide enough to hold the screen size itself (exclusive fill bounds).
  localparam int XW = $clog2(SCREEN_WIDTH + 1);
  localparam int YW = $clog2(SCREEN_HEIGHT + 1);

  localparam logic [2:0] MODE_FILL   = 3'd0;
  localparam logic [2:0] MODE_OPAQUE = 3'd1;
  localparam logic [2:0] MODE_MASK   = 3'd2;
  localparam logic [2:0] MODE_SOURCE = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  localparam logic [1:0] REG_CLIP_X = 2'd0;
  localparam logic [1:0] REG_CLIP_Y = 2'd1;
  localparam logic [1:0] REG_CLIP_W = 2'd2;
  localparam logic [1:0] REG_CLIP_H = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DEC, ST_FILL, ST_SRC, ST_RD, ST_RDO
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_write;
    logic fill_init;
    logic fill_step;
    logic start;
    logic src_init;
    logic src_step;
    logic rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [2:0] mode;
    logic       op_active;
    logic       fill_empty;
    logic       fill_last;
    logic       src_last;
    logic       out_busy;
  } sts_t;

endpackage

// ===== rtl/blt_ctrl.sv =====
`timescale 1ns / 1ps
module blt_ctrl import blt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        state_next = ST_IDLE;
        priority case (sts.mode)
          MODE_FILL: begin
            cmd.fill_init = 1'b1;
            state_next = ST_FILL;
          end
          MODE_OPAQUE, MODE_MASK: cmd.start = 1'b1;
          MODE_SOURCE: begin
            if (sts.op_active) begin
              cmd.src_init = 1'b1;
              state_next = ST_SRC;
            end
          end
          MODE_READ: state_next = ST_RD;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        if (sts.fill_empty) begin
          state_next = ST_IDLE;
        end else begin
          cmd.fill_step = 1'b1;
          if (sts.fill_last) state_next = ST_IDLE;
        end
      end
      ST_SRC: begin
        cmd.src_step = 1'b1;
        if (sts.src_last) state_next = ST_IDLE;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        state_next = ST_RDO;
      end
      ST_RDO: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/blt_dp.sv =====
`timescale 1ns / 1ps
module blt_dp import blt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  mode,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [14:0] size_w,
  input  logic [14:0] size_h,
  input  logic [15:0] color,
  input  logic [15:0] row_bytes,
  input  logic [15:0] src_data,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_value
);

  // Latched input item.
  logic [2:0]  mode_q;
  logic [15:0] px_q, py_q, color_q, stride_q, data_q;
  logic [14:0] w_q, h_q;

  logic [15:0] clip_x, clip_y;
  logic [14:0] clip_w, clip_h;

  // Running copy or mask operation.
  logic        active, opaque;
  logic [15:0] org_x, org_y, ink, row_len, col, row;
  logic [14:0] src_w, src_h;
  logic [2:0]  k;

  // Fill rectangle, already clamped to the screen.
  logic [XW-1:0] fx0, fx1, cx;
  logic [YW-1:0] fy1, cy;
  logic          fempty;

  logic [AW-1:0] clr_addr;
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_data;

  function automatic logic pix_ok(input logic signed [21:0] dx, input logic signed [21:0] dy,
                                  input logic [15:0] cxl, input logic [15:0] cyl,
                                  input logic [14:0] cw, input logic [14:0] ch);
    logic signed [21:0] xl, yl, xh, yh;
    logic on, in_clip;
    xl = 22'($signed(cxl));
    yl = 22'($signed(cyl));
    xh = xl + $signed({7'd0, cw});
    yh = yl + $signed({7'd0, ch});
    on = (dx >= 0) && (dx < 22'(SCREEN_WIDTH)) && (dy >= 0) && (dy < 22'(SCREEN_HEIGHT));
    in_clip = (dx >= xl) && (dx < xh) && (dy >= yl) && (dy < yh);
    return on && ((cw == '0) || (ch == '0) || in_clip);
  endfunction

  // Source pixel position.
  logic [18:0]        sx;
  logic signed [21:0] sdx, sdy, fdx, fdy;
  logic               src_bit, src_we, fill_we;
  logic [16:0]        col_inc, row_inc;

  assign sx      = opaque ? {3'd0, col} : {col, k};
  assign sdx     = 22'($signed(org_x)) + $signed({3'd0, sx});
  assign sdy     = 22'($signed(org_y)) + $signed({6'd0, row});
  assign src_bit = opaque ? 1'b1 : data_q[~k];
  assign src_we  = cmd.src_step && (sx < {4'd0, src_w}) && src_bit &&
                   pix_ok(sdx, sdy, clip_x, clip_y, clip_w, clip_h);
  assign fdx     = $signed({{(22-XW){1'b0}}, cx});
  assign fdy     = $signed({{(22-YW){1'b0}}, cy});
  assign fill_we = cmd.fill_step && pix_ok(fdx, fdy, clip_x, clip_y, clip_w, clip_h);
  assign col_inc = {1'b0, col} + 17'd1;
  assign row_inc = {1'b0, row} + 17'd1;

  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;

  always_comb begin
    we = 1'b0;
    wa = clr_addr;
    wd = 16'h0000;
    priority if (cmd.clr_write) begin
      we = 1'b1;
    end else if (cmd.fill_step) begin
      we = fill_we;
      wa = AW'(cy) * AW'(SCREEN_WIDTH) + AW'(cx);
      wd = color_q;
    end else if (cmd.src_step) begin
      we = src_we;
      wa = AW'(sdy[YW-1:0]) * AW'(SCREEN_WIDTH) + AW'(sdx[XW-1:0]);
      wd = opaque ? data_q : ink;
    end
  end

  logic          rd_on;
  logic [AW-1:0] ra;
  assign rd_on = ($signed(px_q) >= 0) && ($signed(px_q) < 17'sd0 + 16'(SCREEN_WIDTH)) &&
                 ($signed(py_q) >= 0) && ($signed(py_q) < 17'sd0 + 16'(SCREEN_HEIGHT));
  assign ra = AW'(py_q[YW-1:0]) * AW'(SCREEN_WIDTH) + AW'(px_q[XW-1:0]);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd) rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q   <= mode;
      px_q     <= pos_x;
      py_q     <= pos_y;
      w_q      <= size_w;
      h_q      <= size_h;
      color_q  <= color;
      stride_q <= row_bytes;
      data_q   <= src_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_x <= '0;
      clip_y <= '0;
      clip_w <= '0;
      clip_h <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CLIP_X: clip_x <= cfg_data;
        REG_CLIP_Y: clip_y <= cfg_data;
        REG_CLIP_W: clip_w <= cfg_data[14:0];
        REG_CLIP_H: clip_h <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Fill bounds.
  logic signed [17:0] bx0, by0, bx1, by1, ex, ey;
  always_comb begin
    ex  = 18'($signed(px_q)) + $signed({3'd0, w_q});
    ey  = 18'($signed(py_q)) + $signed({3'd0, h_q});
    bx0 = px_q[15] ? 18'sd0 : 18'($signed(px_q));
    by0 = py_q[15] ? 18'sd0 : 18'($signed(py_q));
    bx1 = (ex > 18'(SCREEN_WIDTH))  ? 18'(SCREEN_WIDTH)  : ex;
    by1 = (ey > 18'(SCREEN_HEIGHT)) ? 18'(SCREEN_HEIGHT) : ey;
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_init) begin
      fempty <= (bx0 >= bx1) || (by0 >= by1);
      fx0    <= bx0[XW-1:0];
      fx1    <= bx1[XW-1:0];
      fy1    <= by1[YW-1:0];
      cx     <= bx0[XW-1:0];
      cy     <= by0[YW-1:0];
    end else if (cmd.fill_step) begin
      if (cx + XW'(1) == fx1) begin
        cx <= fx0;
        cy <= cy + YW'(1);
      end else begin
        cx <= cx + XW'(1);
      end
    end
  end

  // Items per source row: the larger of the stride and what the pixels need.
  logic [15:0] per, need;
  assign per  = (mode_q == MODE_OPAQUE) ? {1'b0, stride_q[15:1]} : stride_q;
  assign need = (mode_q == MODE_OPAQUE) ? {1'b0, w_q} : 16'(({1'b0, w_q} + 16'd7) >> 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      opaque <= 1'b0;
      org_x  <= '0;
      org_y  <= '0;
      src_w  <= '0;
      src_h  <= '0;
      ink    <= '0;
      row_len <= '0;
      col    <= '0;
      row    <= '0;
      k      <= '0;
    end else if (cmd.start) begin
      active  <= (w_q != '0) && (h_q != '0);
      opaque  <= (mode_q == MODE_OPAQUE);
      org_x   <= px_q;
      org_y   <= py_q;
      src_w   <= w_q;
      src_h   <= h_q;
      ink     <= color_q;
      row_len <= (per > need) ? per : need;
      col     <= '0;
      row     <= '0;
    end else if (cmd.src_init) begin
      k <= '0;
    end else if (cmd.src_step) begin
      k <= k + 3'd1;
      if (sts.src_last) begin
        if (col_inc >= {1'b0, row_len}) begin
          col <= '0;
          row <= row_inc[15:0];
          if (row_inc >= {2'd0, src_h}) active <= 1'b0;
        end else begin
          col <= col_inc[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) pixel_value <= rd_on ? rd_data : 16'h0000;
  end

  always_comb begin
    sts.clr_last   = (clr_addr == AW'(DEPTH - 1));
    sts.mode       = mode_q;
    sts.op_active  = active;
    sts.fill_empty = fempty;
    sts.fill_last  = (cx + XW'(1) == fx1) && (cy + YW'(1) == fy1);
    sts.src_last   = opaque || (k == 3'd7);
    sts.out_busy   = out_valid && out_stall;
  end

endmodule

// ===== rtl/clipped_rgb565_blitter.sv =====
`timescale 1ns / 1ps
// Each item is latched, then decoded. A fill walks the screen-clamped rectangle pixel by
// pixel (none if empty); an opaque or mask item starts a copy, and each source item in it
// writes one pixel, or up to eight mask pixels one bit at a time (one frame store write
// port); a read waits for a free output register. Items are taken one at a time. A read
// result waits in the output register while the next item is taken. After reset the frame
// store is cleared one pixel a cycle, no items taken; configuration is taken at all times.
module clipped_rgb565_blitter import blt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [14:0] size_w,
  input  logic [14:0] size_h,
  input  logic [15:0] color,
  input  logic [15:0] row_bytes,
  input  logic [15:0] src_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  blt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  blt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .size_w      (size_w),
    .size_h      (size_h),
    .color       (color),
    .row_bytes   (row_bytes),
    .src_data    (src_data),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_value (pixel_value)
  );

endmodule
